@@ sv/tls_pkg.sv @@
// Shared types and constants for the Levinson Toeplitz solver.
// Used by tls_div, tls_ctrl, tls_datapath and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package tls_pkg;

  localparam int MAX_N    = 64;
  localparam int CNT_W    = $clog2(MAX_N);
  localparam int N_W      = $clog2(MAX_N + 1);
  localparam int DATA_W   = 32;
  localparam int IDX_W    = 6;
  localparam int FRAC_W   = 24;
  localparam int MQ_W     = 2 * DATA_W - FRAC_W;
  localparam int ACC_W    = MQ_W + CNT_W + 2;
  localparam int NUM_W    = DATA_W + 2;
  localparam int DVD_W    = NUM_W + FRAC_W;
  localparam logic signed [DATA_W-1:0] Q_ONE = DATA_W'(1 << FRAC_W);

  typedef enum logic [2:0] {
    MAC_NONE, MAC_Q0, MAC_WUPD, MAC_VUPD, MAC_FUPD, MAC_DOTD, MAC_DOTQ
  } mac_t;

  typedef enum logic [1:0] {P_RD, P_MUL, P_WB} phase_t;

  typedef enum logic [1:0] {DS_F0, DS_W, DS_F} dsrc_t;

  typedef struct packed {
    logic             ld_we;
    logic [CNT_W-1:0] ra;
    logic [CNT_W-1:0] ga;
    logic [CNT_W-1:0] fa;
    logic [CNT_W-1:0] wa0;
    logic [CNT_W-1:0] wa1;
    logic [CNT_W-1:0] l;
    logic             wbank;
    mac_t             mac;
    phase_t           ph;
    logic             div_start;
    dsrc_t            dsrc;
    logic             w_one;
    logic             clr;
    logic             fin_d;
    logic             fin_q;
    logic             out_load;
    logic             out_last;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } sts_t;

endpackage
`default_nettype wire

@@ sv/toeplitz_levinson_solver.sv @@
// Symmetric Toeplitz solver (Levinson recursion), top level.
// Instantiates tls_ctrl and tls_datapath; depends on tls_pkg.
//
// Each input transaction loads one lag (autocov, crosscorr); in_last,
// or the MAX_N-th lag, closes the run and fixes the dimension n. The block then
// stops taking input and solves in place with one shared 32x32 multiplier
// (multiply-adds run in read, multiply and write-back phases) and a bit-serial
// divider (two quotients per order step). Each coefficient then goes out as
// one result transaction, index order, last one marked. in_ready stays low
// from the closing lag until the final coefficient is taken.
`timescale 1ns / 1ps
`default_nettype none
module toeplitz_levinson_solver (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic signed [tls_pkg::DATA_W-1:0]   in_autocov,
  input  wire logic signed [tls_pkg::DATA_W-1:0]   in_crosscorr,
  input  wire logic                                in_last,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [tls_pkg::DATA_W-1:0]        out_filter_coef,
  output logic [tls_pkg::IDX_W-1:0]                out_coef_index,
  output logic                                     out_last_coef,
  output logic                                     out_singular
);

  tls_pkg::cmd_t cmd;
  tls_pkg::sts_t sts;

  tls_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_last   (in_last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  tls_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_autocov      (in_autocov),
    .in_crosscorr    (in_crosscorr),
    .out_filter_coef (out_filter_coef),
    .out_coef_index  (out_coef_index),
    .out_last_coef   (out_last_coef),
    .out_singular    (out_singular)
  );

endmodule
`default_nettype wire

@@ sv/tls_div.sv @@
// Restoring divider: rounded Q8.24 quotient num*2^24/den, saturated to 32 bits.
// One quotient bit per cycle; depends on tls_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tls_div (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  input  wire logic signed [tls_pkg::NUM_W-1:0]    num,
  input  wire logic signed [tls_pkg::DATA_W-1:0]   den,
  output logic                                     done,
  output logic                                     sing,
  output logic signed [tls_pkg::DATA_W-1:0]        quo
);

  localparam int CW = $clog2(tls_pkg::DVD_W + 1);

  logic                              busy_r, busy_nxt;
  logic                              done_r, done_nxt;
  logic                              sing_r, sing_nxt;
  logic                              neg_r, neg_nxt;
  logic [CW-1:0]                     cnt_r, cnt_nxt;
  logic [tls_pkg::DVD_W-1:0]         dvd_r, dvd_nxt;
  logic [tls_pkg::DATA_W-1:0]        rem_r, rem_nxt;
  logic [tls_pkg::DATA_W-1:0]        den_r, den_nxt;
  logic signed [tls_pkg::DATA_W-1:0] quo_r, quo_nxt;
  logic [tls_pkg::NUM_W-1:0]         mag;
  logic [tls_pkg::DATA_W-1:0]        trial;
  logic                              qbit;
  logic [tls_pkg::DVD_W-1:0]         qfull;

  always_comb begin
    mag      = num[tls_pkg::NUM_W-1] ? tls_pkg::NUM_W'(-num) : tls_pkg::NUM_W'(num);
    trial    = {rem_r[tls_pkg::DATA_W-2:0], dvd_r[tls_pkg::DVD_W-1]};
    qbit     = (trial >= den_r);
    qfull    = {dvd_r[tls_pkg::DVD_W-2:0], qbit};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    sing_nxt = sing_r;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    if (start) begin
      if (den[tls_pkg::DATA_W-1] || den == '0) begin
        // bad pivot: quotient is zero
        done_nxt = 1'b1;
        sing_nxt = 1'b1;
        quo_nxt  = '0;
      end else begin
        busy_nxt = 1'b1;
        sing_nxt = 1'b0;
        neg_nxt  = num[tls_pkg::NUM_W-1];
        cnt_nxt  = '0;
        rem_nxt  = '0;
        den_nxt  = den;
        dvd_nxt  = {mag, tls_pkg::FRAC_W'(0)}
                 + tls_pkg::DVD_W'(den[tls_pkg::DATA_W-1:1]);
      end
    end else if (busy_r) begin
      rem_nxt = qbit ? trial - den_r : trial;
      dvd_nxt = qfull;
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_r == CW'(tls_pkg::DVD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        if (neg_r) begin
          if (qfull > tls_pkg::DVD_W'(64'h8000_0000)) begin
            quo_nxt = 32'sh8000_0000;
          end else begin
            quo_nxt = -$signed(qfull[tls_pkg::DATA_W-1:0]);
          end
        end else begin
          if (qfull > tls_pkg::DVD_W'(64'h7fff_ffff)) begin
            quo_nxt = 32'sh7fff_ffff;
          end else begin
            quo_nxt = $signed(qfull[tls_pkg::DATA_W-1:0]);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    sing_r <= sing_nxt;
    neg_r  <= neg_nxt;
    cnt_r  <= cnt_nxt;
    dvd_r  <= dvd_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    quo_r  <= quo_nxt;
  end

  assign done = done_r;
  assign sing = sing_r;
  assign quo  = quo_r;

endmodule
`default_nettype wire

@@ sv/tls_datapath.sv @@
// Datapath: lag, predictor and filter stores, shared multiplier, accumulator,
// divider and result register. Driven by tls_ctrl commands; depends on tls_pkg, tls_div.
`timescale 1ns / 1ps
`default_nettype none
module tls_datapath (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire tls_pkg::cmd_t                       cmd,
  output tls_pkg::sts_t                            sts,
  input  wire logic signed [tls_pkg::DATA_W-1:0]   in_autocov,
  input  wire logic signed [tls_pkg::DATA_W-1:0]   in_crosscorr,
  output logic signed [tls_pkg::DATA_W-1:0]        out_filter_coef,
  output logic [tls_pkg::IDX_W-1:0]                out_coef_index,
  output logic                                     out_last_coef,
  output logic                                     out_singular
);

  localparam int DW = tls_pkg::DATA_W;
  localparam int AW = tls_pkg::ACC_W;

  logic signed [DW-1:0] r_mem  [tls_pkg::MAX_N];
  logic signed [DW-1:0] g_mem  [tls_pkg::MAX_N];
  logic signed [DW-1:0] f_mem  [tls_pkg::MAX_N];
  logic signed [DW-1:0] w0_mem [tls_pkg::MAX_N];
  logic signed [DW-1:0] w1_mem [tls_pkg::MAX_N];

  logic signed [DW-1:0] r_rd, g_rd, f_rd;
  logic signed [DW-1:0] w0_rd0, w0_rd1, w1_rd0, w1_rd1;
  logic signed [DW-1:0] w_rd0, w_rd1;

  logic signed [DW-1:0]    v_r, d_r, q_r, wl_r, fl_r;
  logic signed [AW-1:0]    acc_r;
  logic signed [2*DW-1:0]  prod_r;
  logic                    sing_r;
  tls_pkg::dsrc_t          dst_r;

  logic signed [DW-1:0]    op_a, op_b, addend, wb_res;
  logic signed [2*DW-1:0]  rnd;
  logic signed [tls_pkg::MQ_W-1:0] mq;
  logic signed [AW-1:0]    mq_x, sum_x;
  logic signed [tls_pkg::NUM_W-1:0] div_num;
  logic signed [DW-1:0]    div_den, div_quo;
  logic                    div_done, div_sing;
  logic                    is_mul, is_wb;

  logic                 w_we;
  logic [tls_pkg::CNT_W-1:0] w_wa, f_wa;
  logic signed [DW-1:0] w_wd, f_wd;
  logic                 f_we;

  function automatic logic signed [DW-1:0] sat(input logic signed [AW-1:0] x);
    logic signed [AW-1:0] hi, lo;
    hi = {{(AW-DW+1){1'b0}}, {(DW-1){1'b1}}};
    lo = {{(AW-DW+1){1'b1}}, {(DW-1){1'b0}}};
    if (x > hi) begin
      return {1'b0, {(DW-1){1'b1}}};
    end else if (x < lo) begin
      return {1'b1, {(DW-1){1'b0}}};
    end
    return x[DW-1:0];
  endfunction

  function automatic logic signed [AW-1:0] sx(input logic signed [DW-1:0] x);
    return {{(AW-DW){x[DW-1]}}, x};
  endfunction

  assign is_mul = (cmd.ph == tls_pkg::P_MUL);
  assign is_wb  = (cmd.ph == tls_pkg::P_WB);
  assign w_rd0  = cmd.wbank ? w1_rd0 : w0_rd0;
  assign w_rd1  = cmd.wbank ? w1_rd1 : w0_rd1;

  always_comb begin
    op_a   = '0;
    op_b   = '0;
    addend = '0;
    case (cmd.mac)
      tls_pkg::MAC_Q0:   begin op_a = fl_r; op_b = r_rd; end
      tls_pkg::MAC_WUPD: begin op_a = wl_r; op_b = w_rd1; addend = w_rd0; end
      tls_pkg::MAC_VUPD: begin op_a = wl_r; op_b = d_r;   addend = v_r; end
      tls_pkg::MAC_FUPD: begin op_a = fl_r; op_b = w_rd1; addend = f_rd; end
      tls_pkg::MAC_DOTD: begin op_a = w_rd0; op_b = r_rd; end
      tls_pkg::MAC_DOTQ: begin op_a = f_rd; op_b = r_rd; end
      default: ;
    endcase
    // round to Q.24: add half an LSB, then floor
    rnd    = prod_r + (2*DW)'(64'sd8388608);
    mq     = rnd[2*DW-1:tls_pkg::FRAC_W];
    mq_x   = {{(AW-tls_pkg::MQ_W){mq[tls_pkg::MQ_W-1]}}, mq};
    sum_x  = sx(addend) + mq_x;
    wb_res = sat(sum_x);
  end

  always_comb begin
    div_num = '0;
    div_den = v_r;
    case (cmd.dsrc)
      tls_pkg::DS_F0: begin
        div_num = {{2{g_rd[DW-1]}}, g_rd};
        div_den = r_rd;
      end
      tls_pkg::DS_W: div_num = -{{2{d_r[DW-1]}}, d_r};
      tls_pkg::DS_F: div_num = {{2{g_rd[DW-1]}}, g_rd} - {{2{q_r[DW-1]}}, q_r};
      default: ;
    endcase
  end

  tls_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .sing  (div_sing),
    .quo   (div_quo)
  );

  assign sts.div_done = div_done;

  always_comb begin
    w_we = 1'b0;
    w_wa = cmd.wa0;
    w_wd = wb_res;
    f_we = 1'b0;
    f_wa = cmd.fa;
    f_wd = wb_res;
    if (div_done && dst_r == tls_pkg::DS_W) begin
      w_we = 1'b1;
      w_wa = cmd.l;
      w_wd = div_quo;
    end else if (cmd.w_one) begin
      w_we = 1'b1;
      w_wa = '0;
      w_wd = tls_pkg::Q_ONE;
    end else if (cmd.mac == tls_pkg::MAC_WUPD && is_wb) begin
      w_we = 1'b1;
    end
    if (div_done && dst_r == tls_pkg::DS_F0) begin
      f_we = 1'b1;
      f_wa = '0;
      f_wd = div_quo;
    end else if (div_done && dst_r == tls_pkg::DS_F) begin
      f_we = 1'b1;
      f_wa = cmd.l;
      f_wd = div_quo;
    end else if (cmd.mac == tls_pkg::MAC_FUPD && is_wb) begin
      f_we = 1'b1;
    end
  end

  // stores: one write port, registered reads
  always_ff @(posedge clk) begin
    if (cmd.ld_we) begin
      r_mem[cmd.ra] <= in_autocov;
      g_mem[cmd.ra] <= in_crosscorr;
    end
    if (f_we) begin
      f_mem[f_wa] <= f_wd;
    end
    if (w_we && cmd.wbank) begin
      w0_mem[w_wa] <= w_wd;
    end
    if (w_we && !cmd.wbank) begin
      w1_mem[w_wa] <= w_wd;
    end
    r_rd   <= r_mem[cmd.ra];
    g_rd   <= g_mem[cmd.ga];
    f_rd   <= f_mem[cmd.fa];
    w0_rd0 <= w0_mem[cmd.wa0];
    w0_rd1 <= w0_mem[cmd.wa1];
    w1_rd0 <= w1_mem[cmd.wa0];
    w1_rd1 <= w1_mem[cmd.wa1];
  end

  always_ff @(posedge clk) begin
    if (is_mul) begin
      prod_r <= op_a * op_b;
    end
    if (cmd.mac == tls_pkg::MAC_Q0 && is_mul) begin
      d_r <= r_rd;
    end
    if (cmd.mac == tls_pkg::MAC_Q0 && is_wb) begin
      q_r <= wb_res;
    end
    if (cmd.mac == tls_pkg::MAC_VUPD && is_wb) begin
      v_r <= wb_res;
    end
    if (cmd.div_start) begin
      dst_r <= cmd.dsrc;
      if (cmd.dsrc == tls_pkg::DS_F0) begin
        v_r <= r_rd;
      end
    end
    if (div_done) begin
      if (dst_r == tls_pkg::DS_W) begin
        wl_r <= div_quo;
      end else begin
        fl_r <= div_quo;
      end
      if (div_sing) begin
        sing_r <= 1'b1;
      end
    end
    if ((cmd.mac == tls_pkg::MAC_DOTD || cmd.mac == tls_pkg::MAC_DOTQ) && is_wb) begin
      acc_r <= acc_r + mq_x;
    end
    if (cmd.fin_d) begin
      d_r   <= sat(acc_r);
      acc_r <= '0;
    end
    if (cmd.fin_q) begin
      q_r   <= sat(acc_r);
      acc_r <= '0;
    end
    if (cmd.clr) begin
      sing_r <= 1'b0;
      acc_r  <= '0;
    end
    if (cmd.out_load) begin
      out_filter_coef <= f_rd;
      out_coef_index  <= tls_pkg::IDX_W'(cmd.fa);
      out_last_coef   <= cmd.out_last;
      out_singular    <= sing_r;
    end
  end

endmodule
`default_nettype wire

@@ sv/tls_ctrl.sv @@
// Controller: load, Levinson recursion sequencing and result delivery.
// Issues cmd_t to tls_datapath and reads sts_t; depends on tls_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tls_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic            in_last,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output tls_pkg::cmd_t        cmd,
  input  wire tls_pkg::sts_t   sts
);

  localparam int CW = tls_pkg::CNT_W;
  localparam int NW = tls_pkg::N_W;

  typedef enum logic [18:0] {
    S_LOAD  = 19'b000_0000_0000_0000_0001,
    S_INIT  = 19'b000_0000_0000_0000_0010,
    S_DIV0  = 19'b000_0000_0000_0000_0100,
    S_R1    = 19'b000_0000_0000_0000_1000,
    S_Q0    = 19'b000_0000_0000_0001_0000,
    S_DIVW  = 19'b000_0000_0000_0010_0000,
    S_DWAIT = 19'b000_0000_0000_0100_0000,
    S_WONE  = 19'b000_0000_0000_1000_0000,
    S_WUPD  = 19'b000_0000_0001_0000_0000,
    S_VUPD  = 19'b000_0000_0010_0000_0000,
    S_DIVF  = 19'b000_0000_0100_0000_0000,
    S_FUPD  = 19'b000_0000_1000_0000_0000,
    S_DOTD  = 19'b000_0001_0000_0000_0000,
    S_DFIN  = 19'b000_0010_0000_0000_0000,
    S_DOTQ  = 19'b000_0100_0000_0000_0000,
    S_QFIN  = 19'b000_1000_0000_0000_0000,
    S_OUTRD = 19'b001_0000_0000_0000_0000,
    S_OUTLD = 19'b010_0000_0000_0000_0000,
    S_OUTW  = 19'b100_0000_0000_0000_0000
  } state_t;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [NW-1:0]   n_r, n_nxt;
  logic [CW-1:0]   l_r, l_nxt;
  logic [CW-1:0]   j_r, j_nxt;
  tls_pkg::phase_t ph_r, ph_nxt;
  tls_pkg::dsrc_t  dsrc_r, dsrc_nxt;
  logic            bank_r, bank_nxt;
  logic            oval_r, oval_nxt;
  logic            j_is_last_out, l_is_last;

  assign j_is_last_out = (NW'(j_r) == n_r - NW'(1));
  assign l_is_last     = (NW'(l_r) == n_r - NW'(1));

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    n_nxt     = n_r;
    l_nxt     = l_r;
    j_nxt     = j_r;
    ph_nxt    = ph_r;
    dsrc_nxt  = dsrc_r;
    bank_nxt  = bank_r;
    oval_nxt  = oval_r;
    in_ready  = 1'b0;

    cmd       = '0;
    cmd.mac   = tls_pkg::MAC_NONE;
    cmd.ph    = ph_r;
    cmd.dsrc  = dsrc_r;
    cmd.ra    = l_r - j_r + CW'(1);
    cmd.ga    = l_r;
    cmd.fa    = j_r;
    cmd.wa0   = j_r;
    cmd.wa1   = l_r - j_r;
    cmd.l     = l_r;
    cmd.wbank = bank_r;

    unique case (state_r)
      S_LOAD: begin
        in_ready   = 1'b1;
        cmd.ra     = cnt_r;
        cmd.ld_we  = in_valid;
        if (in_valid) begin
          // in_last or a full store closes the run
          if (in_last || cnt_r == CW'(tls_pkg::MAX_N - 1)) begin
            n_nxt     = NW'(cnt_r) + NW'(1);
            cnt_nxt   = '0;
            state_nxt = S_INIT;
          end else begin
            cnt_nxt = cnt_r + CW'(1);
          end
        end
      end
      S_INIT: begin
        cmd.ra    = '0;
        cmd.ga    = '0;
        cmd.clr   = 1'b1;
        state_nxt = S_DIV0;
      end
      S_DIV0: begin
        cmd.ra        = '0;
        cmd.ga        = '0;
        cmd.div_start = 1'b1;
        cmd.dsrc      = tls_pkg::DS_F0;
        dsrc_nxt      = tls_pkg::DS_F0;
        state_nxt     = S_DWAIT;
      end
      S_DWAIT: begin
        if (sts.div_done) begin
          unique case (dsrc_r)
            tls_pkg::DS_F0: begin
              j_nxt     = '0;
              state_nxt = (n_r == NW'(1)) ? S_OUTRD : S_R1;
            end
            tls_pkg::DS_W: state_nxt = S_WONE;
            tls_pkg::DS_F: begin
              j_nxt     = '0;
              ph_nxt    = tls_pkg::P_RD;
              state_nxt = S_FUPD;
            end
            default: state_nxt = S_LOAD;
          endcase
        end
      end
      S_R1: begin
        cmd.ra    = CW'(1);
        ph_nxt    = tls_pkg::P_MUL;
        state_nxt = S_Q0;
      end
      S_Q0: begin
        cmd.ra  = CW'(1);
        cmd.mac = tls_pkg::MAC_Q0;
        if (ph_r == tls_pkg::P_WB) begin
          l_nxt     = CW'(1);
          state_nxt = S_DIVW;
        end else begin
          ph_nxt = tls_pkg::P_WB;
        end
      end
      S_DIVW: begin
        cmd.div_start = 1'b1;
        cmd.dsrc      = tls_pkg::DS_W;
        dsrc_nxt      = tls_pkg::DS_W;
        state_nxt     = S_DWAIT;
      end
      S_WONE: begin
        cmd.w_one = 1'b1;
        if (l_r > CW'(1)) begin
          j_nxt     = CW'(1);
          ph_nxt    = tls_pkg::P_RD;
          state_nxt = S_WUPD;
        end else begin
          bank_nxt  = ~bank_r;
          ph_nxt    = tls_pkg::P_MUL;
          state_nxt = S_VUPD;
        end
      end
      S_WUPD: begin
        cmd.mac = tls_pkg::MAC_WUPD;
        unique case (ph_r)
          tls_pkg::P_RD:  ph_nxt = tls_pkg::P_MUL;
          tls_pkg::P_MUL: ph_nxt = tls_pkg::P_WB;
          default: begin
            ph_nxt = tls_pkg::P_RD;
            if (j_r == l_r - CW'(1)) begin
              // new predictor complete: swap banks
              bank_nxt  = ~bank_r;
              ph_nxt    = tls_pkg::P_MUL;
              state_nxt = S_VUPD;
            end else begin
              j_nxt = j_r + CW'(1);
            end
          end
        endcase
      end
      S_VUPD: begin
        cmd.mac = tls_pkg::MAC_VUPD;
        if (ph_r == tls_pkg::P_WB) begin
          state_nxt = S_DIVF;
        end else begin
          ph_nxt = tls_pkg::P_WB;
        end
      end
      S_DIVF: begin
        cmd.div_start = 1'b1;
        cmd.dsrc      = tls_pkg::DS_F;
        dsrc_nxt      = tls_pkg::DS_F;
        state_nxt     = S_DWAIT;
      end
      S_FUPD: begin
        cmd.mac = tls_pkg::MAC_FUPD;
        unique case (ph_r)
          tls_pkg::P_RD:  ph_nxt = tls_pkg::P_MUL;
          tls_pkg::P_MUL: ph_nxt = tls_pkg::P_WB;
          default: begin
            ph_nxt = tls_pkg::P_RD;
            if (j_r == l_r - CW'(1)) begin
              j_nxt     = '0;
              state_nxt = l_is_last ? S_OUTRD : S_DOTD;
            end else begin
              j_nxt = j_r + CW'(1);
            end
          end
        endcase
      end
      S_DOTD, S_DOTQ: begin
        cmd.mac = (state_r == S_DOTD) ? tls_pkg::MAC_DOTD : tls_pkg::MAC_DOTQ;
        unique case (ph_r)
          tls_pkg::P_RD:  ph_nxt = tls_pkg::P_MUL;
          tls_pkg::P_MUL: ph_nxt = tls_pkg::P_WB;
          default: begin
            ph_nxt = tls_pkg::P_RD;
            if (j_r == l_r) begin
              state_nxt = (state_r == S_DOTD) ? S_DFIN : S_QFIN;
            end else begin
              j_nxt = j_r + CW'(1);
            end
          end
        endcase
      end
      S_DFIN: begin
        cmd.fin_d = 1'b1;
        j_nxt     = '0;
        ph_nxt    = tls_pkg::P_RD;
        state_nxt = S_DOTQ;
      end
      S_QFIN: begin
        cmd.fin_q = 1'b1;
        l_nxt     = l_r + CW'(1);
        state_nxt = S_DIVW;
      end
      S_OUTRD: begin
        state_nxt = S_OUTLD;
      end
      S_OUTLD: begin
        cmd.out_load = 1'b1;
        cmd.out_last = j_is_last_out;
        oval_nxt     = 1'b1;
        state_nxt    = S_OUTW;
      end
      S_OUTW: begin
        if (out_ready) begin
          oval_nxt = 1'b0;
          if (j_is_last_out) begin
            state_nxt = S_LOAD;
          end else begin
            j_nxt     = j_r + CW'(1);
            state_nxt = S_OUTRD;
          end
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      cnt_r   <= '0;
      n_r     <= '0;
      l_r     <= '0;
      j_r     <= '0;
      ph_r    <= tls_pkg::P_RD;
      dsrc_r  <= tls_pkg::DS_F0;
      bank_r  <= 1'b0;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      n_r     <= n_nxt;
      l_r     <= l_nxt;
      j_r     <= j_nxt;
      ph_r    <= ph_nxt;
      dsrc_r  <= dsrc_nxt;
      bank_r  <= bank_nxt;
      oval_r  <= oval_nxt;
    end
  end

  assign out_valid = oval_r;

endmodule
`default_nettype wire

@@ sv/tls_chk.sv @@
// Port-level checker for toeplitz_levinson_solver, bound to the top level.
// Depends on tls_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
module tls_chk (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_valid,
  input wire logic                              in_ready,
  input wire logic                              in_last,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire logic signed [tls_pkg::DATA_W-1:0] out_filter_coef,
  input wire logic [tls_pkg::IDX_W-1:0]         out_coef_index,
  input wire logic                              out_last_coef
);

  logic [tls_pkg::IDX_W-1:0] exp_idx_r;

  // track the expected coefficient index across result transactions
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_idx_r <= '0;
    end else if (out_valid && out_ready) begin
      exp_idx_r <= out_last_coef ? '0 : exp_idx_r + tls_pkg::IDX_W'(1);
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while results pending");

  a_idx_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_coef_index == exp_idx_r)
    else $error("coefficient index out of order");

  a_close_stops_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("load continued after closing lag");

  a_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_coef |=> !in_ready)
    else $error("load reopened before last coefficient");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_filter_coef))
    else $error("stalled result changed");

endmodule

bind toeplitz_levinson_solver tls_chk u_tls_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .in_last         (in_last),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_filter_coef (out_filter_coef),
  .out_coef_index  (out_coef_index),
  .out_last_coef   (out_last_coef)
);
`default_nettype wire
